>>> src/utt_pkg.sv
// Shared types, constants and the per-position scan function of the UTF-8 to UTF-16 transcoder.
// No dependencies; every other file of the block but utt_if imports this package.
package utt_pkg;

    localparam int QueueDepth = 4;

    localparam logic [20:0] ReplChar     = 21'h00FFFD;
    localparam logic [20:0] SuppBase     = 21'h010000;
    localparam logic [20:0] CodeLimit    = 21'h110000;
    localparam logic [20:0] Min3Byte     = 21'h000800;
    localparam logic [20:0] Min2Byte     = 21'h000080;
    localparam logic [20:0] SurrHighBase = 21'h00D800;
    localparam logic [20:0] SurrLowBase  = 21'h00DC00;
    localparam logic [1:0]  ContTag      = 2'b10;

    localparam logic [0:0] FmtUtf16 = 1'b0;
    localparam logic [0:0] FmtUtf32 = 1'b1;

    typedef struct packed {
        logic        emit;
        logic        stop;
        logic [2:0]  next_pos;
        logic [20:0] cp;
        logic        repl;
    } t_step;

    typedef struct packed {
        logic [3:0][20:0] cp;
        logic [3:0]       repl;
        logic [1:0]       last_idx;
        logic             eos;
    } t_entry;

    function automatic logic [2:0] lead_length(logic [7:0] b);
        logic [2:0] len;
        priority if (b[7] == 1'b0)       len = 3'd1;
        else if (b[7:6] == 2'b10)        len = 3'd0;
        else if (b[7:5] == 3'b110)       len = 3'd2;
        else if (b[7:4] == 4'b1110)      len = 3'd3;
        else if (b[7:3] == 5'b11110)     len = 3'd4;
        else                             len = 3'd0;
        return len;
    endfunction

    function automatic t_step scan_step(logic [3:0][7:0] bytes, logic [2:0] pos,
                                        logic [2:0] cnt, logic eos);
        t_step       s;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  len;
        logic [2:0]  rem;
        logic        ok;
        logic [20:0] v;
        s          = '0;
        s.next_pos = pos;
        s.cp       = ReplChar;
        s.repl     = 1'b1;
        b0  = bytes[pos[1:0]];
        b1  = bytes[pos[1:0] + 2'd1];
        b2  = bytes[pos[1:0] + 2'd2];
        b3  = bytes[pos[1:0] + 2'd3];
        len = lead_length(b0);
        rem = cnt - pos;
        ok  = 1'b0;
        v   = '0;
        if (pos < cnt) begin
            if (len == 3'd0) begin
                s.emit     = 1'b1;
                s.next_pos = pos + 3'd1;
            end else if (rem < len) begin
                if (eos) begin
                    s.emit     = 1'b1;
                    s.next_pos = pos + 3'd1;
                end else begin
                    s.stop = 1'b1;
                end
            end else begin
                ok = (len < 3'd2 || b1[7:6] == ContTag)
                  && (len < 3'd3 || b2[7:6] == ContTag)
                  && (len < 3'd4 || b3[7:6] == ContTag);
                unique case (len)
                    3'd1: begin
                        v = {13'd0, b0};
                    end
                    3'd2: begin
                        v  = {10'd0, b0[4:0], b1[5:0]};
                        ok = ok && (v >= Min2Byte);
                    end
                    3'd3: begin
                        v  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                        ok = ok && (v >= Min3Byte);
                    end
                    default: begin
                        v  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                        ok = ok && (v >= SuppBase) && (v < CodeLimit);
                    end
                endcase
                s.emit = 1'b1;
                if (ok) begin
                    s.cp       = v;
                    s.repl     = 1'b0;
                    s.next_pos = pos + len;
                end else begin
                    s.next_pos = pos + 3'd1;
                end
            end
        end
        return s;
    endfunction

endpackage

>>> src/utt_if.sv
// Valid/ready channel interfaces for the byte input and the code unit output.
// No dependencies.
interface utt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;
    modport source (output valid, in_byte, end_of_stream, input ready);
    modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface utt_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_unit;
    logic        replaced;
    logic        last_in_run;
    logic        stream_done;
    modport source (output valid, code_unit, replaced, last_in_run, stream_done, input ready);
    modport sink   (input valid, code_unit, replaced, last_in_run, stream_done, output ready);
endinterface

>>> src/utt_front.sv
// Front end: joins held bytes with the new byte, scans up to four positions, keeps the tail.
// Depends on utt_pkg.
module utt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    output logic            o_push,
    output utt_pkg::t_entry o_entry
);
    import utt_pkg::*;

    logic [2:0][7:0] r_held;
    logic [1:0]      r_held_cnt;
    logic [2:0][7:0] n_held;
    logic [1:0]      n_held_cnt;

    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic [4:0][2:0] pos;
    t_step [3:0]     st;
    logic [3:0]      emits;
    logic [2:0]      n_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bytes[i] = (2'(i) < r_held_cnt) ? r_held[i] : i_byte;
        end
        bytes[3] = i_byte;
        cnt      = {1'b0, r_held_cnt} + 3'd1;
        pos[0]   = 3'd0;
        for (int k = 0; k < 4; k++) begin
            st[k]     = scan_step(bytes, pos[k], cnt, i_eos);
            pos[k+1]  = st[k].next_pos;
            emits[k]  = st[k].emit;
        end
        n_held_cnt = 2'(cnt - pos[4]);
        for (int i = 0; i < 3; i++) begin
            n_held[i] = bytes[pos[4][1:0] + 2'(i)];
        end
        n_res = 3'($countones(emits));
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_entry.cp[k]   = st[k].cp;
            o_entry.repl[k] = st[k].repl;
        end
        o_entry.last_idx = 2'(n_res - 3'd1);
        o_entry.eos      = i_eos;
        o_push           = i_accept && emits[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
        end else if (i_accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

>>> src/utt_queue.sv
// Short queue of decoded entries between the front end and the unit sequencer.
// Depends on utt_pkg.
module utt_queue #(
    parameter int DEPTH = utt_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utt_pkg::t_entry i_entry,
    input  logic            i_pop,
    output utt_pkg::t_entry o_head,
    output logic            o_full,
    output logic            o_empty
);
    import utt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

>>> src/utt_back.sv
// Back end: walks the head entry, splits supplementary code points into surrogate pairs,
// and drives the registered output. Depends on utt_pkg.
module utt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fmt,
    input  utt_pkg::t_entry i_head,
    input  logic            i_empty,
    input  logic            i_ready,
    output logic            o_pop,
    output logic            o_valid,
    output logic [20:0]     o_code_unit,
    output logic            o_replaced,
    output logic            o_last_in_run,
    output logic            o_stream_done
);
    import utt_pkg::*;

    logic [1:0]  r_idx;
    logic        r_half;
    logic        r_valid;
    logic [20:0] r_unit;
    logic        r_repl;
    logic        r_last;
    logic        r_done;

    logic [20:0] cp;
    logic [20:0] off;
    logic        split;
    logic        last_unit;
    logic        load;
    logic [20:0] n_unit;

    always_comb begin
        cp        = i_head.cp[r_idx];
        off       = cp - SuppBase;
        split     = (i_fmt == FmtUtf16) && (cp >= SuppBase);
        last_unit = (!split || r_half) && (r_idx == i_head.last_idx);
        load      = !i_empty && (!r_valid || i_ready);
        o_pop     = load && last_unit;
        if (!split) begin
            n_unit = cp;
        end else if (!r_half) begin
            n_unit = SurrHighBase | {11'd0, off[19:10]};
        end else begin
            n_unit = SurrLowBase | {11'd0, cp[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (split && !r_half) begin
                    r_half <= 1'b1;
                end else begin
                    r_half <= 1'b0;
                    r_idx  <= last_unit ? 2'd0 : r_idx + 2'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= n_unit;
            r_repl <= i_head.repl[r_idx];
            r_last <= last_unit;
            r_done <= last_unit && i_head.eos;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_unit   = r_unit;
    assign o_replaced    = r_repl;
    assign o_last_in_run = r_last;
    assign o_stream_done = r_done;

endmodule

>>> src/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16/UTF-32 transcoder top level: format register, front end, queue, back end.
// Depends on utt_pkg, utt_if, utt_front, utt_queue, utt_back.
// Path: the first result of an accepted byte is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; the output register sends one unit per
// cycle while the sink is ready, with a DEPTH-entry queue absorbing bursts of multi-unit bytes.
// Reset: synchronous; clears held bytes count, queue, output valid, and selects UTF-16.
module utf8_to_utf16_transcoder #(
    parameter int DEPTH = utt_pkg::QueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    utt_in_if.sink    i_in,
    utt_out_if.source o_out
);
    import utt_pkg::*;

    logic   r_fmt;
    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    logic   accept;
    t_entry entry;
    t_entry head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FmtUtf16;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && !q_full;

    utt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eos    (i_in.end_of_stream),
        .o_push   (push),
        .o_entry  (entry)
    );

    utt_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    utt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fmt         (r_fmt),
        .i_head        (head),
        .i_empty       (q_empty),
        .i_ready       (o_out.ready),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .o_code_unit   (o_out.code_unit),
        .o_replaced    (o_out.replaced),
        .o_last_in_run (o_out.last_in_run),
        .o_stream_done (o_out.stream_done)
    );

endmodule

>>> src/utt_checker.sv
// Port-level checks of the transcoder output channel, and the bind that attaches them.
// Depends on utt_pkg and the transcoder top level.
module utt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [20:0] i_code_unit,
    input logic        i_replaced,
    input logic        i_last,
    input logic        i_done
);
    import utt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_unit) && $stable(i_replaced)
            && $stable(i_last) && $stable(i_done))
        else $error("output item changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done |-> i_last)
        else $error("stream end without end of run");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_code_unit < CodeLimit)
        else $error("code unit out of range");

    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_replaced |-> i_code_unit == ReplChar)
        else $error("replaced item is not the replacement character");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_utt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_code_unit (o_out.code_unit),
    .i_replaced  (o_out.replaced),
    .i_last      (o_out.last_in_run),
    .i_done      (o_out.stream_done)
);

>>> bench/tb_utf8_to_utf16_transcoder.sv
// Self-checking testbench of the UTF-8 to UTF-16/UTF-32 transcoder: a directed UTF-16 stream and random
// byte streams under both output formats, with random idling on both channels but in the back-to-back test.
// Depends on utt_pkg, utt_if and utf8_to_utf16_transcoder.
module tb_utf8_to_utf16_transcoder;
    import utt_pkg::*;

    typedef struct {
        logic [20:0] unit;
        logic        repl;
        logic        last;
        logic        done;
    } t_unit;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    utt_in_if  byte_if ();
    utt_out_if unit_if ();

    utf8_to_utf16_transcoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_if),
        .o_out       (unit_if)
    );

    logic [7:0]  hold_bytes [3];
    int          hold_count;
    logic [0:0]  out_format;
    t_unit       units_due [$];
    bit          no_idle;
    int          errors;
    int          bytes_sent;
    int          units_checked;
    int          repl_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int seq_len(logic [7:0] b);
        if (b < 8'h80) return 1;
        if (b < 8'hC0) return 0;
        if (b < 8'hE0) return 2;
        if (b < 8'hF0) return 3;
        if (b < 8'hF8) return 4;
        return 0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eos);
        logic [7:0]  seq [4];
        logic [20:0] units [8];
        logic        flags [8];
        logic [20:0] cp;
        logic        ok;
        int unsigned v;
        int          n;
        int          cnt;
        int          pos;
        int          len;
        int          i;
        t_unit       u;
        for (i = 0; i < hold_count; i++) seq[i] = hold_bytes[i];
        seq[hold_count] = b;
        cnt = hold_count + 1;
        pos = 0;
        n   = 0;
        while (pos < cnt) begin
            len = seq_len(seq[pos]);
            ok  = 1'b0;
            if (len != 0 && cnt - pos < len && !eos) break;
            if (len != 0 && cnt - pos >= len) begin
                ok = 1'b1;
                for (i = 1; i < len; i++) begin
                    if (seq[pos + i][7:6] != 2'b10) ok = 1'b0;
                end
                case (len)
                    1: v = 32'(seq[pos]);
                    2: begin
                        v  = 32'({seq[pos][4:0], seq[pos + 1][5:0]});
                        ok = ok && (v >= 'h80);
                    end
                    3: begin
                        v  = 32'({seq[pos][3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]});
                        ok = ok && (v >= 'h800);
                    end
                    default: begin
                        v  = 32'({seq[pos][2:0], seq[pos + 1][5:0], seq[pos + 2][5:0],
                                  seq[pos + 3][5:0]});
                        ok = ok && (v >= 'h10000) && (v < 'h110000);
                    end
                endcase
            end
            if (ok) begin
                cp  = v[20:0];
                pos = pos + len;
            end else begin
                cp  = ReplChar;
                pos = pos + 1;
            end
            if (out_format == FmtUtf32 || cp < 21'h10000) begin
                units[n] = cp;
                flags[n] = !ok;
                n++;
            end else begin
                units[n]     = ((cp - 21'h10000) >> 10) + SurrHighBase;
                flags[n]     = 1'b0;
                units[n + 1] = {11'd0, cp[9:0]} + SurrLowBase;
                flags[n + 1] = 1'b0;
                n = n + 2;
            end
        end
        hold_count = cnt - pos;
        for (i = 0; i < hold_count; i++) hold_bytes[i] = seq[pos + i];
        for (i = 0; i < n; i++) begin
            u.unit = units[i];
            u.repl = flags[i];
            u.last = (i == n - 1);
            u.done = (i == n - 1) && eos;
            units_due.push_back(u);
        end
    endfunction

    task automatic send_item(logic [7:0] b, logic eos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid         <= 1'b1;
        byte_if.in_byte       <= b;
        byte_if.end_of_stream <= eos;
        do @(posedge i_clk); while (!byte_if.ready);
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (units_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_format(logic [0:0] fmt);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        out_format = fmt;
    endtask

    task automatic send_random_stream(int count);
        logic [7:0]  seq [4];
        int unsigned cp;
        int          kind;
        int          nb;
        int          i;
        int          stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            case ($urandom_range(1, 4))
                1: begin
                    cp = $urandom_range(0, 'h7F);
                    seq[0] = cp[7:0];
                    nb = 1;
                end
                2: begin
                    cp = $urandom_range('h80, 'h7FF);
                    seq[0] = {3'b110, cp[10:6]};
                    seq[1] = {2'b10, cp[5:0]};
                    nb = 2;
                end
                3: begin
                    cp = $urandom_range('h800, 'hFFFF);
                    seq[0] = {4'b1110, cp[15:12]};
                    seq[1] = {2'b10, cp[11:6]};
                    seq[2] = {2'b10, cp[5:0]};
                    nb = 3;
                end
                default: begin
                    cp = $urandom_range('h10000, 'h10FFFF);
                    seq[0] = {5'b11110, cp[20:18]};
                    seq[1] = {2'b10, cp[17:12]};
                    seq[2] = {2'b10, cp[11:6]};
                    seq[3] = {2'b10, cp[5:0]};
                    nb = 4;
                end
            endcase
            if (kind >= 12 && kind <= 13 && nb > 1) begin
                nb = $urandom_range(1, nb - 1);
            end else if (kind >= 14 && kind <= 15 && nb > 1) begin
                seq[$urandom_range(1, nb - 1)] = 8'($urandom_range(0, 255));
            end else if (kind >= 16 && kind <= 17) begin
                case ($urandom_range(0, 6))
                    0: seq[0] = 8'hC0;
                    1: seq[0] = 8'hC1;
                    2: seq[0] = 8'hE0;
                    3: seq[0] = 8'hED;
                    4: seq[0] = 8'hF0;
                    5: seq[0] = 8'hF4;
                    default: seq[0] = 8'hF5;
                endcase
                nb = seq_len(seq[0]);
                for (i = 1; i < nb; i++) seq[i] = 8'($urandom_range('h80, 'hBF));
            end else if (kind >= 18) begin
                seq[0] = 8'($urandom_range(0, 255));
                nb = 1;
            end
            for (i = 0; i < nb; i++) send_item(seq[i], $urandom_range(0, 49) == 0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
    endtask

    task automatic test_directed();
        write_format(FmtUtf16);
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hC2, 1'b0);
        send_item(8'h80, 1'b0);
        // overlong two-byte form, then its tail as a stray continuation
        send_item(8'hC0, 1'b0);
        send_item(8'hAF, 1'b0);
        // a properly encoded U+FFFF is not a replacement
        send_item(8'hEF, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hBF, 1'b0);
        // surrogate in three-byte form passes through
        send_item(8'hED, 1'b0);
        send_item(8'hA0, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hF4, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'hBF, 1'b0);
        send_item(8'hBF, 1'b0);
        // above U+10FFFF: lead rejected, three stray continuations follow
        send_item(8'hF4, 1'b0);
        send_item(8'h90, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hF8, 1'b0);
        send_item(8'hFF, 1'b0);
        // bad continuation, rescanned as ASCII
        send_item(8'hE2, 1'b0);
        send_item(8'h41, 1'b0);
        // truncated sequence flushed at end of stream
        send_item(8'hF0, 1'b0);
        send_item(8'h90, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_utf32();
        no_idle = 1'b0;
        write_format(FmtUtf32);
        send_random_stream(120);
    endtask

    task automatic test_random_utf16();
        no_idle = 1'b0;
        write_format(FmtUtf16);
        send_random_stream(120);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        write_format(FmtUtf32);
        send_random_stream(110);
        no_idle = 1'b0;
    endtask

    initial begin
        int stall;
        unit_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                unit_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            unit_if.ready <= 1'b1;
            do @(posedge i_clk); while (!unit_if.valid);
        end
    end

    always @(posedge i_clk) begin
        t_unit want;
        if (i_rst_n && unit_if.valid && unit_if.ready) begin
            if (units_due.size() == 0) begin
                $display("%0t: unexpected unit, expected none, got unit=%h repl=%b last=%b done=%b",
                         $time, unit_if.code_unit, unit_if.replaced, unit_if.last_in_run,
                         unit_if.stream_done);
                errors++;
            end else begin
                want = units_due.pop_front();
                if (unit_if.code_unit !== want.unit || unit_if.replaced !== want.repl
                    || unit_if.last_in_run !== want.last || unit_if.stream_done !== want.done)
                begin
                    $display("%0t: mismatch expected unit=%h repl=%b last=%b done=%b",
                             $time, want.unit, want.repl, want.last, want.done);
                    $display("%0t:          actual   unit=%h repl=%b last=%b done=%b",
                             $time, unit_if.code_unit, unit_if.replaced,
                             unit_if.last_in_run, unit_if.stream_done);
                    errors++;
                end
                units_checked++;
                if (want.repl) repl_seen++;
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= 1'b0;
        byte_if.valid         <= 1'b0;
        byte_if.in_byte       <= 8'h00;
        byte_if.end_of_stream <= 1'b0;
        hold_count    = 0;
        out_format    = FmtUtf16;
        no_idle       = 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        units_checked = 0;
        repl_seen     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_utf32();
        test_random_utf16();
        test_back_to_back();
        if (units_due.size() != 0) begin
            $display("%0t: %0d units never arrived", $time, units_due.size());
            errors++;
        end
        $display("Sent %0d bytes in UTF-16 and UTF-32 modes; checked %0d units (%0d replacements).",
                 bytes_sent, units_checked, repl_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
src/utt_pkg.sv
src/utt_if.sv
src/utt_front.sv
src/utt_queue.sv
src/utt_back.sv
src/utf8_to_utf16_transcoder.sv
src/utt_checker.sv
bench/tb_utf8_to_utf16_transcoder.sv
